FILE: hw/rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// shared constants for the point-in-tetrahedron test
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_VERTEX  = 4;
    localparam int FACE_STAGES = 5;
    localparam int LATENCY     = FACE_STAGES + 1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D = 2'd3;

endpackage

FILE: hw/rtl/pit_face.sv
// ----------------------------------------------------------------------------
// pit_face
// five-stage signed volume pipeline for one face: edge differences, normal
// partial products, normal, triple product terms, sums; then sign test
// ----------------------------------------------------------------------------
module pit_face
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_f0  [3],
    input  logic signed [COORD_WIDTH-1:0] i_f1  [3],
    input  logic signed [COORD_WIDTH-1:0] i_f2  [3],
    input  logic signed [COORD_WIDTH-1:0] i_opp [3],
    input  logic signed [COORD_WIDTH-1:0] i_pt  [3],
    output logic                          o_ok,
    output logic                          o_flat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int TW = NW + DW;
    localparam int SW = TW + 2;

    // stage 1: differences
    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_e2 [3];
    logic signed [DW-1:0] r_eo1 [3];
    logic signed [DW-1:0] r_ep1 [3];
    // stage 2: normal partial products
    logic signed [PW-1:0] r_m [6];
    logic signed [DW-1:0] r_eo2 [3];
    logic signed [DW-1:0] r_ep2 [3];
    // stage 3: normal
    logic signed [NW-1:0] r_n [3];
    logic signed [DW-1:0] r_eo3 [3];
    logic signed [DW-1:0] r_ep3 [3];
    // stage 4: triple product terms
    logic signed [TW-1:0] r_qo [3];
    logic signed [TW-1:0] r_qp [3];
    // stage 5: dd and dp
    logic signed [SW-1:0] r_dd;
    logic signed [SW-1:0] r_dp;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e1[k]  <= DW'(i_f0[k]) - DW'(i_f1[k]);
            r_e2[k]  <= DW'(i_f0[k]) - DW'(i_f2[k]);
            r_eo1[k] <= DW'(i_f0[k]) - DW'(i_opp[k]);
            r_ep1[k] <= DW'(i_f0[k]) - DW'(i_pt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
        r_m[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
        r_m[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
        r_m[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
        r_m[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
        r_m[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
        r_eo2  <= r_eo1;
        r_ep2  <= r_ep1;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_n[k] <= NW'(r_m[2*k]) - NW'(r_m[2*k+1]);
        end
        r_eo3 <= r_eo2;
        r_ep3 <= r_ep2;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_qo[k] <= TW'(r_n[k]) * TW'(r_eo3[k]);
            r_qp[k] <= TW'(r_n[k]) * TW'(r_ep3[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dd <= SW'(r_qo[0]) + SW'(r_qo[1]) + SW'(r_qo[2]);
        r_dp <= SW'(r_qp[0]) + SW'(r_qp[1]) + SW'(r_qp[2]);
    end

    always_comb begin
        o_flat = (r_dd == '0);
        if (r_dd == '0 || r_dp == '0) begin
            o_ok = 1'b0;
        end else if (r_dd > 0) begin
            o_ok = (r_dp > 0) && (r_dp <= r_dd);
        end else begin
            o_ok = (r_dp < 0) && (r_dp >= r_dd);
        end
    end

endmodule

FILE: hw/rtl/point_in_tetrahedron_test.sv
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// signed volume test of a point stream against a configured tetrahedron
// ----------------------------------------------------------------------------
// One point is taken in every clock cycle (busy stays low) and its result
// word appears on o_is_inside / o_degenerate with o_done high once it has
// passed the five register stages of the face pipeline, which runs all
// four faces side by side, and then the output register. The receiver
// cannot hold results off, so none is held back. The user must write the
// vertex registers through i_cfg_we / i_cfg_idx / i_cfg_data only while
// no point is in flight; the block itself does not enforce this.
module point_in_tetrahedron_test
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_done,
    output logic                          o_is_inside,
    output logic                          o_degenerate
);

    localparam int EXT_W = 3 * COORD_WIDTH + CFG_W;

    logic [CFG_W-1:0]              r_vtx [NUM_VERTEX];
    logic [FACE_STAGES-1:0]        r_vld;
    logic                          r_done;
    logic                          r_inside;
    logic                          r_degen;
    logic [EXT_W-1:0]              w_ext [NUM_VERTEX];
    logic signed [COORD_WIDTH-1:0] w_v   [NUM_VERTEX][3];
    logic signed [COORD_WIDTH-1:0] w_pt  [3];
    logic [3:0]                    w_ok;
    logic [3:0]                    w_flat;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VERTEX; v++) begin
                r_vtx[v] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VERTEX_A: r_vtx[0] <= i_cfg_data;
                REG_VERTEX_B: r_vtx[1] <= i_cfg_data;
                REG_VERTEX_C: r_vtx[2] <= i_cfg_data;
                REG_VERTEX_D: r_vtx[3] <= i_cfg_data;
                default:      r_vtx[0] <= r_vtx[0];
            endcase
        end
    end

    // unpack x, y, z low to high; bits past the register read as zero
    always_comb begin
        for (int v = 0; v < NUM_VERTEX; v++) begin
            w_ext[v] = EXT_W'(r_vtx[v]);
            for (int k = 0; k < 3; k++) begin
                w_v[v][k] = w_ext[v][k*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    pit_face #(.COORD_WIDTH(COORD_WIDTH)) u_face_abc (
        .i_clk(i_clk), .i_f0(w_v[0]), .i_f1(w_v[1]), .i_f2(w_v[2]),
        .i_opp(w_v[3]), .i_pt(w_pt), .o_ok(w_ok[0]), .o_flat(w_flat[0])
    );

    pit_face #(.COORD_WIDTH(COORD_WIDTH)) u_face_abd (
        .i_clk(i_clk), .i_f0(w_v[0]), .i_f1(w_v[1]), .i_f2(w_v[3]),
        .i_opp(w_v[2]), .i_pt(w_pt), .o_ok(w_ok[1]), .o_flat(w_flat[1])
    );

    pit_face #(.COORD_WIDTH(COORD_WIDTH)) u_face_acd (
        .i_clk(i_clk), .i_f0(w_v[0]), .i_f1(w_v[2]), .i_f2(w_v[3]),
        .i_opp(w_v[1]), .i_pt(w_pt), .o_ok(w_ok[2]), .o_flat(w_flat[2])
    );

    pit_face #(.COORD_WIDTH(COORD_WIDTH)) u_face_bcd (
        .i_clk(i_clk), .i_f0(w_v[1]), .i_f1(w_v[2]), .i_f2(w_v[3]),
        .i_opp(w_v[0]), .i_pt(w_pt), .o_ok(w_ok[3]), .o_flat(w_flat[3])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[FACE_STAGES-2:0], start & ~busy};
            r_done <= r_vld[FACE_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= &w_ok;
        r_degen  <= |w_flat;
    end

    assign o_done       = r_done;
    assign o_is_inside  = r_inside;
    assign o_degenerate = r_degen;

endmodule

FILE: hw/rtl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// port-level timing and result checks, bound to the top level
// ----------------------------------------------------------------------------
module pit_checker
    import pit_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_is_inside,
    input logic o_degenerate
);

    logic w_acc;

    assign w_acc = start & ~busy & i_rst_n;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LATENCY o_done)
        else $error("word taken but no result after pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LATENCY))
        else $error("result word without a matching input word");

    a_flat_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_inside && o_degenerate))
        else $error("flat tetrahedron reported a point inside");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a fully pipelined block");

endmodule

bind point_in_tetrahedron_test pit_checker u_pit_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_done(o_done),
    .o_is_inside(o_is_inside),
    .o_degenerate(o_degenerate)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the point-in-tetrahedron test
// ----------------------------------------------------------------------------
// Streams points against a series of tetrahedra: the all-zero reset
// setting, hand-picked unit, mirrored, full-range corner and flat shapes,
// then random shapes of several kinds. Most random points are blends of the
// current vertices, some on faces, at vertices or nudged across a face; the
// rest are full-range noise or edge values. Each accepted point is scored
// by an exact integer signed-volume predictor. Its verdict is queued and
// compared with the result word that the block strobes out. The start side
// idles at random, and vertices are only rewritten once the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import pit_pkg::*;

    localparam int CW = 16;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } point_t;

    typedef struct packed {
        logic in_tet;
        logic flat;
    } verdict_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_VERTEX_A;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] i_point_x = '0;
    logic signed [CW-1:0] i_point_y = '0;
    logic signed [CW-1:0] i_point_z = '0;
    logic                 o_done;
    logic                 o_is_inside;
    logic                 o_degenerate;

    logic [CFG_W-1:0] vtx [NUM_VERTEX];
    point_t           point_q [$];
    verdict_t         verdict_q [$];
    point_t           next_pt;
    verdict_t         want;
    int               gap_left = 0;
    bit               no_gaps = 1'b0;
    int               mismatches = 0;
    int               n_points = 0;
    int               n_results = 0;
    int               n_inside = 0;
    int               n_flat = 0;
    int               n_settings = 0;

    point_in_tetrahedron_test #(
        .COORD_WIDTH(CW)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_done       (o_done),
        .o_is_inside  (o_is_inside),
        .o_degenerate (o_degenerate)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint coord(logic [CFG_W-1:0] v, int k);
        return longint'($signed(v[k*CW +: CW]));
    endfunction

    function automatic longint signed_volume(logic [CFG_W-1:0] f0, logic [CFG_W-1:0] f1,
                                             logic [CFG_W-1:0] f2, logic [CFG_W-1:0] q);
        longint e1 [3];
        longint e2 [3];
        longint e3 [3];
        for (int k = 0; k < 3; k++) begin
            e1[k] = coord(f0, k) - coord(f1, k);
            e2[k] = coord(f0, k) - coord(f2, k);
            e3[k] = coord(f0, k) - coord(q, k);
        end
        return (e1[1] * e2[2] - e1[2] * e2[1]) * e3[0]
             + (e1[2] * e2[0] - e1[0] * e2[2]) * e3[1]
             + (e1[0] * e2[1] - e1[1] * e2[0]) * e3[2];
    endfunction

    function automatic verdict_t predict_verdict(point_t p);
        logic [CFG_W-1:0] f0, f1, f2, opp;
        longint dd, dp;
        verdict_t r;
        r.in_tet = 1'b1;
        r.flat = 1'b0;
        for (int f = 0; f < 4; f++) begin
            case (f)
                0: begin
                    f0 = vtx[REG_VERTEX_A]; f1 = vtx[REG_VERTEX_B];
                    f2 = vtx[REG_VERTEX_C]; opp = vtx[REG_VERTEX_D];
                end
                1: begin
                    f0 = vtx[REG_VERTEX_A]; f1 = vtx[REG_VERTEX_B];
                    f2 = vtx[REG_VERTEX_D]; opp = vtx[REG_VERTEX_C];
                end
                2: begin
                    f0 = vtx[REG_VERTEX_A]; f1 = vtx[REG_VERTEX_C];
                    f2 = vtx[REG_VERTEX_D]; opp = vtx[REG_VERTEX_B];
                end
                default: begin
                    f0 = vtx[REG_VERTEX_B]; f1 = vtx[REG_VERTEX_C];
                    f2 = vtx[REG_VERTEX_D]; opp = vtx[REG_VERTEX_A];
                end
            endcase
            dd = signed_volume(f0, f1, f2, opp);
            dp = signed_volume(f0, f1, f2, p);
            if (dd == 0) begin
                r.flat = 1'b1;
                r.in_tet = 1'b0;
            end else if (dp == 0 || (dd > 0 && (dp < 0 || dp > dd))
                         || (dd < 0 && (dp > 0 || dp < dd))) begin
                r.in_tet = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint rand_coord(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] make_vertex(longint x, longint y, longint z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic point_t blend_point(int wa, int wb, int wc, int wd);
        logic [CFG_W-1:0] r;
        longint sum;
        longint total;
        total = wa + wb + wc + wd;
        for (int k = 0; k < 3; k++) begin
            sum = wa * coord(vtx[REG_VERTEX_A], k) + wb * coord(vtx[REG_VERTEX_B], k)
                + wc * coord(vtx[REG_VERTEX_C], k) + wd * coord(vtx[REG_VERTEX_D], k);
            r[k*CW +: CW] = CW'(sum / total);
        end
        return point_t'(r);
    endfunction

    function automatic point_t nudge_point(point_t p, int span);
        logic [CFG_W-1:0] r;
        for (int k = 0; k < 3; k++)
            r[k*CW +: CW] = CW'(clamp16(coord(p, k) + rand_coord(span)));
        return point_t'(r);
    endfunction

    function automatic longint edge_coord();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return -1;
            3: return 0;
            default: return 1;
        endcase
    endfunction

    // driver: one point word per start, random idle gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy)
                verdict_q.push_back(predict_verdict({i_point_z, i_point_y, i_point_x}));
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (point_q.size() != 0) begin
                    next_pt = point_q.pop_front();
                    i_point_x <= next_pt.x;
                    i_point_y <= next_pt.y;
                    i_point_z <= next_pt.z;
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: result word against the oldest verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: inside %0b degenerate %0b",
                             o_is_inside, o_degenerate);
            end else begin
                want = verdict_q.pop_front();
                n_results++;
                if (want.in_tet) n_inside++;
                if (want.flat) n_flat++;
                if (o_is_inside !== want.in_tet || o_degenerate !== want.flat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected inside %0b degenerate %0b, got %0b %0b",
                                 n_results, want.in_tet, want.flat, o_is_inside,
                                 o_degenerate);
                end
            end
        end
    end

    task automatic send_point(longint x, longint y, longint z);
        point_q.push_back(point_t'(make_vertex(x, y, z)));
        n_points++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        vtx[idx] = data;
    endtask

    task automatic program_tetra(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
                                 logic [CFG_W-1:0] c, logic [CFG_W-1:0] d);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_VERTEX_D, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (point_q.size() != 0 || start || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic random_tetra(int kind);
        logic [CFG_W-1:0] v [4];
        longint s, t;
        int span;
        case (kind)
            0: begin
                for (int k = 0; k < 4; k++) v[k] = 48'({$urandom(), $urandom()});
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: span = 4;
                    1: span = 50;
                    default: span = 2000;
                endcase
                for (int k = 0; k < 4; k++)
                    v[k] = make_vertex(rand_coord(span), rand_coord(span), rand_coord(span));
            end
            2: begin
                for (int k = 0; k < 4; k++)
                    v[k] = make_vertex($urandom_range(0, 1) ? -32768 : 32767,
                                       $urandom_range(0, 1) ? -32768 : 32767,
                                       $urandom_range(0, 1) ? -32768 : 32767);
            end
            3: begin
                for (int k = 0; k < 3; k++)
                    v[k] = make_vertex(rand_coord(1000), rand_coord(1000), rand_coord(1000));
                s = rand_coord(2);
                t = rand_coord(2);
                for (int k = 0; k < 3; k++)
                    v[3][k*CW +: CW] = CW'(coord(v[0], k)
                        + s * (coord(v[1], k) - coord(v[0], k))
                        + t * (coord(v[2], k) - coord(v[0], k)));
            end
            default: begin
                for (int k = 0; k < 4; k++)
                    v[k] = make_vertex(rand_coord(20000), rand_coord(20000), rand_coord(20000));
                v[$urandom_range(1, 3)] = v[0];
            end
        endcase
        program_tetra(v[0], v[1], v[2], v[3]);
    endtask

    task automatic random_points(int count);
        int wa, wb, wc, wd, m;
        point_t p;
        for (int n = 0; n < count; n++) begin
            m = $urandom_range(0, 99);
            wa = $urandom_range(0, 15);
            wb = $urandom_range(0, 15);
            wc = $urandom_range(0, 15);
            wd = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: wa = 0;
                    1: wb = 0;
                    2: wc = 0;
                    default: wd = 0;
                endcase
            end
            if (wa + wb + wc + wd == 0) wa = 1;
            if (m < 50) begin
                p = blend_point(wa, wb, wc, wd);
            end else if (m < 60) begin
                if ($urandom_range(0, 1))
                    p = point_t'(vtx[$urandom_range(0, 3)]);
                else
                    p = blend_point(1, 1, 0, 0);
            end else if (m < 78) begin
                p = nudge_point(blend_point(wa, wb, wc, wd), $urandom_range(1, 3));
            end else if (m < 90) begin
                p = point_t'(48'({$urandom(), $urandom()}));
            end else begin
                p = point_t'(make_vertex(edge_coord(), edge_coord(), edge_coord()));
            end
            point_q.push_back(p);
            n_points++;
        end
    endtask

    initial begin
        foreach (vtx[k]) vtx[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: all vertices at the origin
        send_point(0, 0, 0);
        send_point(32767, 32767, 32767);
        send_point(-32768, -32768, -32768);
        drain();

        program_tetra(make_vertex(0, 0, 0), make_vertex(100, 0, 0),
                      make_vertex(0, 100, 0), make_vertex(0, 0, 100));
        send_point(10, 10, 10);
        send_point(0, 10, 10);
        send_point(10, 10, 100);
        send_point(0, 0, 100);
        send_point(25, 25, 25);
        send_point(40, 40, 20);
        send_point(-1, 10, 10);
        send_point(32767, -32768, 0);
        send_point(-32768, 32767, -1);
        drain();

        // mirrored winding
        program_tetra(make_vertex(0, 0, 0), make_vertex(0, 100, 0),
                      make_vertex(100, 0, 0), make_vertex(0, 0, 100));
        send_point(10, 10, 10);
        send_point(0, 10, 10);
        send_point(1, 1, 97);
        send_point(33, 33, 33);
        send_point(200, 0, 0);
        drain();

        program_tetra(make_vertex(-32768, -32768, -32768), make_vertex(32767, -32768, -32768),
                      make_vertex(-32768, 32767, -32768), make_vertex(-32768, -32768, 32767));
        send_point(-32767, -32767, -32767);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(-10000, -10000, -10000);
        drain();

        // flat: fourth vertex in the plane of the first three
        program_tetra(make_vertex(0, 0, 0), make_vertex(100, 0, 0),
                      make_vertex(0, 100, 0), make_vertex(50, 50, 0));
        send_point(10, 10, 0);
        send_point(10, 10, 10);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            random_tetra(ph < 10 ? ph % 5 : $urandom_range(0, 4));
            random_points(150 + $urandom_range(0, 10));
            drain();
        end

        $display("%0d points checked over %0d vertex settings", n_points, n_settings);
        $display("%0d results inside, %0d on flat shapes", n_inside, n_flat);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
